/* sv/vzc_pkg.sv */
// Shared constants, codes and control structs for the varint/zig-zag codec.
package vzc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int GROUP_BITS  = 7;
  localparam int MAX_GROUPS  = (VALUE_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
  localparam int ACC_WIDTH   = MAX_GROUPS * GROUP_BITS;
  localparam int CNT_WIDTH   = $clog2(MAX_GROUPS);
  localparam int SHAMT_WIDTH = $clog2(ACC_WIDTH);

  // Operation selector carried on in_tuser
  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  // Result kind carried on out_tuser
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Top to encoder
  typedef struct packed {
    logic load;      // take a new value into the shifter
    logic step;      // a byte is emitted this cycle, shift by one group
    logic zigzag;    // map the loaded value to unsigned zig-zag form
  } enc_ctrl_t;

  // Encoder to top
  typedef struct packed {
    logic busy;      // bytes still to emit
    logic more;      // current group is not the final one
  } enc_stat_t;

endpackage

/* sv/vzc_enc.sv */
// Varint encoder: a value shift register that drops one seven-bit group per byte.
module vzc_enc
  import vzc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  enc_ctrl_t              ctrl,
  input  logic [VALUE_WIDTH-1:0] load_value,
  output enc_stat_t              stat,
  output logic [GROUP_BITS-1:0]  grp
);

  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic                   busy_r, busy_nxt;
  logic [VALUE_WIDTH-1:0] mapped;
  logic                   more;

  // Zig-zag: shift left, flip all bits for negative values
  always_comb begin
    mapped = load_value;
    if (ctrl.zigzag) begin
      mapped = {load_value[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{load_value[VALUE_WIDTH-1]}};
    end
  end

  // Groups above the current one still hold set bits
  assign more = |sh_r[VALUE_WIDTH-1:GROUP_BITS];

  always_comb begin
    sh_nxt   = sh_r;
    busy_nxt = busy_r;
    if (ctrl.load) begin
      sh_nxt   = mapped;
      busy_nxt = 1'b1;
    end else if (ctrl.step) begin
      sh_nxt   = sh_r >> GROUP_BITS;
      busy_nxt = more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign grp       = sh_r[GROUP_BITS-1:0];
  assign stat.busy = busy_r;
  assign stat.more = more;

endmodule

/* sv/varint_zigzag_codec.sv */
// Top level of the LEB128 varint codec with optional zig-zag mapping.
//
//  channel  dir  tdata                                tuser      tlast
//  in_      in   [31:0] value_in, [39:32] byte_in     func       -
//  out_     out  [7:0] byte_out, [39:8] value_out     kind       last
//  cfg_     in   cfg_wdata: signed_mode               -          -
//
// Encode: the value shifter is loaded, then gives one byte per cycle unless the
// output stalls, so an item gives n bytes (1..5); the shifter drops one seven-bit
// group per byte. Decode: one byte per cycle when not stalled or encoding, into a
// group shift register. Reset is synchronous, active low, and clears the decode
// state and the overflow flag. A stalled output beat holds and blocks new input.
module varint_zigzag_codec
  import vzc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value_in, [39:32] byte_in
  input  logic        in_tuser,   // [0] func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] byte_out, [39:8] value_out
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(MAX_GROUPS - 1);

  logic signed_r;

  logic [ACC_WIDTH-1:0]   acc_r, acc_nxt;
  logic [CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  out_kind_r, out_kind_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                   out_last_r, out_last_nxt;

  enc_ctrl_t              enc_ctrl;
  enc_stat_t              enc_stat;
  logic [GROUP_BITS-1:0]  enc_grp;

  logic                   slot_free;
  logic                   in_acc;
  func_t                  in_func;
  logic [7:0]             in_byte;

  logic [ACC_WIDTH-1:0]   dec_shifted;
  logic [SHAMT_WIDTH-1:0] dec_shamt;
  logic [ACC_WIDTH-1:0]   dec_aligned;
  logic [VALUE_WIDTH-1:0] dec_u;
  logic [VALUE_WIDTH-1:0] dec_value;

  assign in_func   = func_t'(in_tuser);
  assign in_byte   = in_tdata[39:32];
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = !enc_stat.busy && slot_free;
  assign in_acc    = in_tvalid && in_tready;

  // Encoder control
  assign enc_ctrl.load   = in_acc && (in_func == FUNC_ENCODE);
  assign enc_ctrl.step   = enc_stat.busy && slot_free;
  assign enc_ctrl.zigzag = signed_r;

  vzc_enc u_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (enc_ctrl),
    .load_value (in_tdata[VALUE_WIDTH-1:0]),
    .stat       (enc_stat),
    .grp        (enc_grp)
  );

  // Decode datapath: new group enters at the top, then align by group count
  assign dec_shifted = {in_byte[GROUP_BITS-1:0], acc_r[ACC_WIDTH-1:GROUP_BITS]};
  assign dec_shamt   = SHAMT_WIDTH'((CNT_LAST - cnt_r) * GROUP_BITS);
  assign dec_aligned = dec_shifted >> dec_shamt;
  assign dec_u       = dec_aligned[VALUE_WIDTH-1:0];

  always_comb begin
    dec_value = dec_u;
    if (signed_r) begin
      dec_value = (dec_u >> 1) ^ {VALUE_WIDTH{dec_u[0]}};
    end
  end

  // Decode state and output register
  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    if (enc_ctrl.step) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_BYTE;
      out_byte_nxt  = {enc_stat.more, enc_grp};
      out_value_nxt = '0;
      out_last_nxt  = !enc_stat.more;
    end else if (in_acc && (in_func == FUNC_DECODE)) begin
      if (ovf_r) begin
        // sticky error: state untouched
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ERROR;
        out_byte_nxt  = '0;
        out_value_nxt = '1;
        out_last_nxt  = 1'b1;
      end else if (!in_byte[7]) begin
        acc_nxt       = dec_shifted;
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_VALUE;
        out_byte_nxt  = '0;
        out_value_nxt = dec_value;
        out_last_nxt  = 1'b1;
      end else if (cnt_r == CNT_LAST) begin
        // continuation on the final group position
        ovf_nxt       = 1'b1;
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ERROR;
        out_byte_nxt  = '0;
        out_value_nxt = '1;
        out_last_nxt  = 1'b1;
      end else begin
        acc_nxt = dec_shifted;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_r    <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        signed_r <= cfg_wdata;
      end
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_value_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_no_take_while_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    enc_stat.busy |-> !in_tready)
    else $error("input taken while encoder busy");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_ERROR)) |-> (out_value_r == '1) && out_last_r)
    else $error("error beat without all-ones value or last");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_group_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("group count beyond last group");

  a_byte_last_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_BYTE)) |-> (out_last_r != out_byte_r[7]))
    else $error("encoded byte continuation bit disagrees with last");

endmodule

/* bench/tb_varint_zigzag_codec.sv */
// Self-checking testbench for the varint/zig-zag codec: directed vectors, random streams, then overflow rows.
module tb_varint_zigzag_codec;
  import vzc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 12;   // longest encode gives five bytes
  localparam int OPEN_ROWS    = 24;   // directed rows before the random part
  localparam int PLAN_ROWS    = 33;
  localparam int PHASE_ITEMS  = 64;
  localparam int MAX_REPORTS  = 20;

  // One result beat as it appears on the out_ channel
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  octet;
    logic [31:0] value;
    logic        tail;
  } beat_t;

  // One directed row: either a mode write or an input beat
  typedef struct packed {
    bit          wr_cfg;
    bit          mode;
    func_t       func;
    logic [31:0] val;
    logic [7:0]  octet;
    bit          known;   // beat below is the whole expected result
    beat_t       beat;
  } vec_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [31:0] value_in, [39:32] byte_in
  logic        in_tuser = 1'b0;  // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [7:0] byte_out, [39:8] value_out
  logic [1:0]  out_tuser;        // [1:0] kind
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Typed expectation travelling in step with the input beat
  bit          typed_known = 1'b0;
  beat_t       typed_beat = '0;

  // Predictor state
  logic [31:0] pred_acc = '0;
  int          pred_groups = 0;
  bit          pred_overflow = 1'b0;
  bit          pred_zigzag = 1'b0;

  beat_t       step_beats[$];
  beat_t       beats_due[$];
  int          err_count = 0;
  int          cycle_cnt = 0;
  int          burst_left = 0;
  rx_style_t   rx_style = RX_OPEN;
  int          rx_left = 0;
  int          rx_tick = 0;

  localparam beat_t ERR_BEAT = '{KIND_ERROR, 8'h00, 32'hFFFF_FFFF, 1'b1};

  vec_t plan_vecs [PLAN_ROWS] = '{
    // unsigned mode: encode extremes
    '{1'b1, 1'b0, FUNC_ENCODE, 32'h0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h0, 8'hC3, 1'b1, '{KIND_BYTE, 8'h00, 32'h0, 1'b1}},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h7F, 8'hC3, 1'b1, '{KIND_BYTE, 8'h7F, 32'h0, 1'b1}},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h80, 8'h3C, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h8000_0000, 8'h00, 1'b0, '0},
    // single-byte decodes
    '{1'b0, 1'b0, FUNC_DECODE, 32'hA5A5_5A5A, 8'h00, 1'b1, '{KIND_VALUE, 8'h00, 32'h0, 1'b1}},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h5A5A_A5A5, 8'h7F, 1'b1, '{KIND_VALUE, 8'h00, 32'h7F, 1'b1}},
    // five-byte decode, encode in the middle, excess bits in the last byte
    '{1'b0, 1'b0, FUNC_DECODE, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'hFF, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h1234_5678, 8'hFF, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'hFF, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'hFF, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h7F, 1'b0, '0},
    // non-minimal zero
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h80, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h00, 1'b0, '0},
    // signed mode
    '{1'b1, 1'b1, FUNC_ENCODE, 32'h0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h0, 8'h81, 1'b1, '{KIND_BYTE, 8'h00, 32'h0, 1'b1}},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'hFFFF_FFFF, 8'h00, 1'b1, '{KIND_BYTE, 8'h01, 32'h0, 1'b1}},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h1, 8'h00, 1'b1, '{KIND_BYTE, 8'h02, 32'h0, 1'b1}},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h7FFF_FFFF, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h8000_0000, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h01, 1'b1, '{KIND_VALUE, 8'h00, 32'hFFFF_FFFF, 1'b1}},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h02, 1'b1, '{KIND_VALUE, 8'h00, 32'h1, 1'b1}},
    // overflow: fifth continuation byte raises the sticky flag
    '{1'b1, 1'b0, FUNC_ENCODE, 32'h0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h80, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h80, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h80, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h80, 1'b0, '0},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h80, 1'b1, ERR_BEAT},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h00, 1'b1, ERR_BEAT},
    '{1'b0, 1'b0, FUNC_DECODE, 32'h0, 8'h7F, 1'b1, ERR_BEAT},
    '{1'b0, 1'b0, FUNC_ENCODE, 32'h5, 8'h80, 1'b1, '{KIND_BYTE, 8'h05, 32'h0, 1'b1}}
  };

  varint_zigzag_codec uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Work out the result beats of one accepted input beat into step_beats
  function automatic void codec_step(func_t func, logic [31:0] value, logic [7:0] octet);
    logic [31:0] v;
    logic [63:0] grp_bits;
    beat_t       b;
    step_beats.delete();
    if (func == FUNC_ENCODE) begin
      v = value;
      if (pred_zigzag) v = {value[30:0], 1'b0} ^ {32{value[31]}};
      do begin
        b.kind  = KIND_BYTE;
        b.value = '0;
        b.octet = {1'b0, v[6:0]};
        v = v >> GROUP_BITS;
        b.octet[7] = (v != 0);
        b.tail = (v == 0);
        step_beats.push_back(b);
      end while (v != 0);
    end else if (pred_overflow) begin
      step_beats.push_back(ERR_BEAT);
    end else begin
      grp_bits = 64'(octet[6:0]) << (pred_groups * GROUP_BITS);
      pred_acc = pred_acc | grp_bits[31:0];
      pred_groups++;
      if (!octet[7]) begin
        v = pred_acc;
        pred_acc = '0;
        pred_groups = 0;
        if (pred_zigzag) v = (v >> 1) ^ {32{v[0]}};
        step_beats.push_back('{KIND_VALUE, 8'h00, v, 1'b1});
      end else if (pred_groups * GROUP_BITS >= VALUE_WIDTH) begin
        pred_overflow = 1'b1;
        pred_acc = '0;
        pred_groups = 0;
        step_beats.push_back(ERR_BEAT);
      end
    end
  endfunction

  // Scoreboard: predict on input beats, compare on output beats
  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (rst_n) begin
      if (cfg_we) pred_zigzag = cfg_wdata;
      if (in_tvalid && in_tready) begin
        codec_step(func_t'(in_tuser), in_tdata[31:0], in_tdata[39:32]);
        if (typed_known) begin
          step_beats.delete();
          step_beats.push_back(typed_beat);
        end
        foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
      end
      if (out_tvalid && out_tready) begin
        got = '{kind_t'(out_tuser), out_tdata[7:0], out_tdata[39:8], out_tlast};
        if (beats_due.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected beat kind=%0d byte=%02h value=%08h last=%0b",
                     $time, got.kind, got.octet, got.value, got.tail);
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: mismatch expected kind=%0d byte=%02h value=%08h last=%0b %s",
                       $time, want.kind, want.octet, want.value, want.tail,
                       $sformatf("got kind=%0d byte=%02h value=%08h last=%0b",
                                 got.kind, got.octet, got.value, got.tail));
          end
        end
      end
    end
  end

  // Receiver: back-pressure in changing styles
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 80);
    end
    rx_left--;
    rx_tick++;
    case (rx_style)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= (rx_tick % 5) < 2;
    endcase
  end

  function automatic logic [31:0] rand_value();
    int k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        k = $urandom_range(1, 31);
        return $urandom & ((32'd1 << k) - 1);
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return -$urandom_range(1, 300);
    endcase
  endfunction

  // Send one input beat; bursts with random gaps between them
  task automatic drive_item(func_t func, logic [31:0] value, logic [7:0] octet,
                            bit known, beat_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid   <= 1'b1;
    in_tdata    <= {octet, value};
    in_tuser    <= func;
    typed_known <= known;
    typed_beat  <= beat;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and let every expected beat come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    // let the scoreboard queue the last accepted beat first
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic walk_vectors(int lo, int hi);
    for (int r = lo; r < hi; r++) begin
      if (plan_vecs[r].wr_cfg) write_mode(plan_vecs[r].mode);
      else drive_item(plan_vecs[r].func, plan_vecs[r].val, plan_vecs[r].octet,
                      plan_vecs[r].known, plan_vecs[r].beat);
    end
  endtask

  // Mostly well-formed varint streams with encodes mixed in, plus loose bytes
  task automatic random_phase(int quota);
    int          sent;
    int          open_cont;
    int          n;
    int          pick;
    logic [34:0] wide;
    logic [7:0]  octet;
    sent = 0;
    open_cont = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        drive_item(FUNC_ENCODE, rand_value(), 8'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end else if (pick < 8) begin
        // close a loose sequence so this one starts clean
        if (open_cont != 0) begin
          drive_item(FUNC_DECODE, $urandom, 8'($urandom_range(0, 127)), 1'b0, '0);
          open_cont = 0;
          sent++;
        end
        wide = {3'b000, rand_value()};
        if ($urandom_range(0, 3) == 0) wide[34:32] = 3'($urandom_range(0, 7));
        n = 1;
        while (n < 5 && (wide >> (7 * n)) != 0) n++;
        if ($urandom_range(0, 4) == 0) n = $urandom_range(n, 5);
        for (int i = 0; i < n; i++) begin
          octet = {i != n - 1, wide[7 * i +: 7]};
          drive_item(FUNC_DECODE, $urandom, octet, 1'b0, '0);
          sent++;
          if (i != n - 1 && $urandom_range(0, 5) == 0) begin
            drive_item(FUNC_ENCODE, rand_value(), 8'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
          end
        end
      end else begin
        // loose byte, never a fifth continuation
        octet = 8'($urandom_range(0, 255));
        if (open_cont == 4) octet[7] = 1'b0;
        drive_item(FUNC_DECODE, $urandom, octet, 1'b0, '0);
        open_cont = octet[7] ? open_cont + 1 : 0;
        sent++;
      end
    end
    if (open_cont != 0)
      drive_item(FUNC_DECODE, $urandom, 8'($urandom_range(0, 127)), 1'b0, '0);
  endtask

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    walk_vectors(0, OPEN_ROWS);
    for (int p = 0; p < 4; p++) begin
      write_mode(p[0]);
      random_phase(PHASE_ITEMS);
    end

    // overflow last: the flag only clears on reset
    walk_vectors(OPEN_ROWS, PLAN_ROWS);
    write_mode(1'b1);
    repeat (30) begin
      if ($urandom_range(0, 1) != 0)
        drive_item(FUNC_DECODE, $urandom, 8'($urandom_range(0, 255)), 1'b0, '0);
      else
        drive_item(FUNC_ENCODE, rand_value(), 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    wait_idle();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
